// ===== hdl/btcc_pkg.sv =====
// ----------------------------------------------------------------------------
// btcc_pkg
// shared constants and types of the box/triangle/circle collision tester
// ----------------------------------------------------------------------------
package btcc_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int OP_WIDTH        = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_BOX      = 2'd0,
        OP_TRIANGLE = 2'd1,
        OP_CIRCLE   = 2'd2,
        OP_NONE     = 2'd3
    } t_op;
endpackage

// ===== hdl/btcc_diff.sv =====
// ----------------------------------------------------------------------------
// btcc_diff
// stage 1: edge compares, vertex-in-box tests and coordinate differences
// ----------------------------------------------------------------------------
module btcc_diff #(
    parameter int CW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [1:0]              i_op,
    input  logic signed [CW-1:0]    i_l,
    input  logic signed [CW-1:0]    i_r,
    input  logic signed [CW-1:0]    i_t,
    input  logic signed [CW-1:0]    i_b,
    input  logic signed [CW-1:0]    i_o [6],
    output logic [1:0]              o_op,
    output logic                    o_box_hit,
    output logic                    o_vtx_hit,
    // triangle: corner c, edge k -> ax,ay,bx,by ; circle uses point diffs
    output logic signed [CW+1:0]    o_d [4][3][4],
    output logic signed [CW:0]      o_cd [8][2],
    output logic signed [CW-1:0]    o_rad
);
    import btcc_pkg::*;
    localparam int DW = CW + 2;

    logic signed [CW:0] w_px [4];
    logic signed [CW:0] w_py [4];
    logic signed [CW:0] w_qx [8];
    logic signed [CW:0] w_qy [8];
    logic               n_box, n_vtx;

    always_comb begin
        // corners lt, rt, rb, lb
        w_px[0] = {i_l[CW-1], i_l}; w_py[0] = {i_t[CW-1], i_t};
        w_px[1] = {i_r[CW-1], i_r}; w_py[1] = {i_t[CW-1], i_t};
        w_px[2] = {i_r[CW-1], i_r}; w_py[2] = {i_b[CW-1], i_b};
        w_px[3] = {i_l[CW-1], i_l}; w_py[3] = {i_b[CW-1], i_b};
        // eight circle sample points
        w_qx[0] = {i_l[CW-1], i_l};       w_qy[0] = {i_t[CW-1], i_t};
        w_qx[1] = {i_o[3][CW-1], i_o[3]}; w_qy[1] = {i_t[CW-1], i_t};
        w_qx[2] = {i_r[CW-1], i_r};       w_qy[2] = {i_t[CW-1], i_t};
        w_qx[3] = {i_l[CW-1], i_l};       w_qy[3] = {i_o[4][CW-1], i_o[4]};
        w_qx[4] = {i_r[CW-1], i_r};       w_qy[4] = {i_o[4][CW-1], i_o[4]};
        w_qx[5] = {i_l[CW-1], i_l};       w_qy[5] = {i_b[CW-1], i_b};
        w_qx[6] = {i_o[3][CW-1], i_o[3]}; w_qy[6] = {i_b[CW-1], i_b};
        w_qx[7] = {i_r[CW-1], i_r};       w_qy[7] = {i_b[CW-1], i_b};
        n_box = (w_px[1] + (CW+1)'(1) >= $signed({i_o[0][CW-1], i_o[0]}))
             && (w_px[0] - (CW+1)'(1) <= $signed({i_o[1][CW-1], i_o[1]}))
             && (w_py[2] + (CW+1)'(1) >= $signed({i_o[2][CW-1], i_o[2]}))
             && (w_py[0] - (CW+1)'(1) <= $signed({i_o[3][CW-1], i_o[3]}));
        n_vtx = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (i_o[2*k] > i_l && i_o[2*k] < i_r && i_o[2*k+1] > i_t && i_o[2*k+1] < i_b)
                n_vtx = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_op      <= i_op;
            o_box_hit <= n_box;
            o_vtx_hit <= n_vtx;
            o_rad     <= i_o[2];
            for (int c = 0; c < 4; c++) begin
                for (int k = 0; k < 3; k++) begin
                    o_d[c][k][0] <= DW'(i_o[2*k]) - DW'(w_px[c]);
                    o_d[c][k][1] <= DW'(i_o[2*k+1]) - DW'(w_py[c]);
                    o_d[c][k][2] <= DW'(i_o[2*((k+1)%3)]) - DW'(w_px[c]);
                    o_d[c][k][3] <= DW'(i_o[2*((k+1)%3)+1]) - DW'(w_py[c]);
                end
            end
            for (int p = 0; p < 8; p++) begin
                o_cd[p][0] <= w_qx[p] - $signed({i_o[0][CW-1], i_o[0]});
                o_cd[p][1] <= w_qy[p] - $signed({i_o[1][CW-1], i_o[1]});
            end
        end
    end
endmodule

// ===== hdl/btcc_mul.sv =====
// ----------------------------------------------------------------------------
// btcc_mul
// stage 2: area cross products and squared distances
// ----------------------------------------------------------------------------
module btcc_mul #(
    parameter int CW = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [1:0]                i_op,
    input  logic                      i_box_hit,
    input  logic                      i_vtx_hit,
    input  logic signed [CW+1:0]      i_d [4][3][4],
    input  logic signed [CW:0]        i_cd [8][2],
    input  logic signed [CW-1:0]      i_rad,
    output logic [1:0]                o_op,
    output logic                      o_box_hit,
    output logic                      o_vtx_hit,
    output logic signed [2*CW+3:0]    o_pa [4][3],
    output logic signed [2*CW+3:0]    o_pb [4][3],
    output logic signed [2*CW+1:0]    o_sx [8],
    output logic signed [2*CW+1:0]    o_sy [8],
    output logic signed [2*CW+1:0]    o_rr
);
    import btcc_pkg::*;
    localparam int PW = 2*CW + 4;
    localparam int SW = 2*CW + 2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_op      <= i_op;
            o_box_hit <= i_box_hit;
            o_vtx_hit <= i_vtx_hit;
            o_rr      <= SW'(i_rad) * SW'(i_rad);
            for (int c = 0; c < 4; c++) begin
                for (int k = 0; k < 3; k++) begin
                    o_pa[c][k] <= PW'(i_d[c][k][0]) * PW'(i_d[c][k][3]);
                    o_pb[c][k] <= PW'(i_d[c][k][1]) * PW'(i_d[c][k][2]);
                end
            end
            for (int p = 0; p < 8; p++) begin
                o_sx[p] <= SW'(i_cd[p][0]) * SW'(i_cd[p][0]);
                o_sy[p] <= SW'(i_cd[p][1]) * SW'(i_cd[p][1]);
            end
        end
    end
endmodule

// ===== hdl/btcc_decide.sv =====
// ----------------------------------------------------------------------------
// btcc_decide
// stage 3: area signs, distance compares and the final hit select
// ----------------------------------------------------------------------------
module btcc_decide #(
    parameter int CW = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [1:0]                i_op,
    input  logic                      i_box_hit,
    input  logic                      i_vtx_hit,
    input  logic signed [2*CW+3:0]    i_pa [4][3],
    input  logic signed [2*CW+3:0]    i_pb [4][3],
    input  logic signed [2*CW+1:0]    i_sx [8],
    input  logic signed [2*CW+1:0]    i_sy [8],
    input  logic signed [2*CW+1:0]    i_rr,
    output logic                      o_hit
);
    import btcc_pkg::*;
    localparam int PW = 2*CW + 4;

    logic n_hit, w_tri, w_circ, w_pos, w_neg;
    logic signed [PW-1:0] w_a;

    always_comb begin
        w_tri = 1'b0;
        for (int c = 0; c < 4; c++) begin
            w_pos = 1'b0;
            w_neg = 1'b0;
            for (int k = 0; k < 3; k++) begin
                w_a = i_pa[c][k] - i_pb[c][k];
                if (w_a < 0) w_neg = 1'b1;
                else if (w_a != 0) w_pos = 1'b1;
            end
            if (!(w_pos && w_neg)) w_tri = 1'b1;
        end
        w_circ = 1'b0;
        for (int p = 0; p < 8; p++) begin
            if ({1'b0, i_sx[p]} + {1'b0, i_sy[p]} < {1'b0, i_rr}) w_circ = 1'b1;
        end
        unique case (t_op'(i_op))
            OP_BOX:      n_hit = i_box_hit;
            OP_TRIANGLE: n_hit = i_vtx_hit || w_tri;
            OP_CIRCLE:   n_hit = w_circ;
            default:     n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit <= n_hit;
        end
    end
endmodule

// ===== hdl/box_triangle_circle_collision.sv =====
// an accepted item passes the difference, multiply and decide registers in turn to the master side
// throughput: one item per cycle while the master side does not stall; the three stages (differences, multiplies,
// compare and select) each hold one item
// a stalled master side holds the whole pipe; no bubbles are lost or repeated
// reset (synchronous, active low) clears the stage valid bits only
// ----------------------------------------------------------------------------
// box_triangle_circle_collision
// three-stage pipelined box versus box/triangle/circle hit test
// ----------------------------------------------------------------------------
module box_triangle_circle_collision #(
    parameter int COORD_WIDTH = btcc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // box_left, box_right, box_top, box_bottom, other_0 .. other_5
    input  logic [10*COORD_WIDTH-1:0]     s_axis_tdata,
    // op
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit, zero padded to a byte
    output logic [7:0]                    m_axis_tdata
);
    import btcc_pkg::*;
    localparam int CW = COORD_WIDTH;

    logic r_v1, r_v2, r_v3;
    logic w_en;
    logic signed [CW-1:0] w_o [6];

    logic [1:0] w_op1, w_op2;
    logic w_bh1, w_vh1, w_bh2, w_vh2, w_hit;
    logic signed [CW+1:0] w_d [4][3][4];
    logic signed [CW:0] w_cd [8][2];
    logic signed [CW-1:0] w_rad;
    logic signed [2*CW+3:0] w_pa [4][3];
    logic signed [2*CW+3:0] w_pb [4][3];
    logic signed [2*CW+1:0] w_sx [8];
    logic signed [2*CW+1:0] w_sy [8];
    logic signed [2*CW+1:0] w_rr;

    // the pipe moves as a whole whenever the output slot is free or drained
    assign w_en          = !r_v3 || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {7'd0, w_hit};

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_o[k] = s_axis_tdata[(4+k)*CW +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    btcc_diff #(.CW(CW)) u_diff (
        .i_clk(i_clk), .i_en(w_en), .i_op(s_axis_tuser),
        .i_l(s_axis_tdata[0 +: CW]), .i_r(s_axis_tdata[CW +: CW]),
        .i_t(s_axis_tdata[2*CW +: CW]), .i_b(s_axis_tdata[3*CW +: CW]),
        .i_o(w_o), .o_op(w_op1), .o_box_hit(w_bh1), .o_vtx_hit(w_vh1),
        .o_d(w_d), .o_cd(w_cd), .o_rad(w_rad)
    );

    btcc_mul #(.CW(CW)) u_mul (
        .i_clk(i_clk), .i_en(w_en), .i_op(w_op1), .i_box_hit(w_bh1),
        .i_vtx_hit(w_vh1), .i_d(w_d), .i_cd(w_cd), .i_rad(w_rad),
        .o_op(w_op2), .o_box_hit(w_bh2), .o_vtx_hit(w_vh2),
        .o_pa(w_pa), .o_pb(w_pb), .o_sx(w_sx), .o_sy(w_sy), .o_rr(w_rr)
    );

    btcc_decide #(.CW(CW)) u_decide (
        .i_clk(i_clk), .i_en(w_en), .i_op(w_op2), .i_box_hit(w_bh2),
        .i_vtx_hit(w_vh2), .i_pa(w_pa), .i_pb(w_pb), .i_sx(w_sx),
        .i_sy(w_sy), .i_rr(w_rr), .o_hit(w_hit)
    );

`ifndef SYNTH
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !m_axis_tready |=> r_v3 && $stable(w_hit))
        else $error("result changed under stall");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_v2 |=> r_v3)
        else $error("item lost between stages");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> s_axis_tready)
        else $error("input blocked with empty output");
`endif
endmodule
